/* hw/rtl/lhd_pkg.sv */
// Shared types, constants and status codes of the LZW history decoder.
// Used by lhd_ram users and the top level lzw_history_decoder_core.
`timescale 1ns / 1ps

package lhd_pkg;

   // Storage sizes.
   localparam int DICT_ENTRIES  = 4096;
   localparam int DICT_BITS     = 12;
   localparam int HISTORY_BYTES = 65536;
   localparam int HIST_BITS     = 16;
   localparam int MAX_CODE_BITS = 12;

   // Code values with a fixed meaning, the smallest code width and the largest entry length.
   localparam logic [11:0] CODE_CLEAR    = 12'd256;
   localparam logic [11:0] CODE_END      = 12'd257;
   localparam logic [12:0] FIRST_ENTRY   = 13'd258;
   localparam logic [3:0]  MIN_CODE_BITS = 4'd9;
   localparam logic [11:0] LEN_MAX       = 12'd4095;

   // Output limit after reset.
   localparam logic [16:0] LIMIT_RESET = 17'h10000;

   // Input item kinds.
   localparam logic KIND_BYTE  = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   // Run state codes.
   localparam logic [2:0] RUN_GO    = 3'd0;
   localparam logic [2:0] RUN_END   = 3'd1;
   localparam logic [2:0] RUN_LIMIT = 3'd2;
   localparam logic [2:0] RUN_EOF   = 3'd3;
   localparam logic [2:0] RUN_BAD   = 3'd4;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        out_valid;
      logic        more_pending;
      logic [2:0]  run_state;
      logic [16:0] bytes_produced;
   } rsp_type;

   // One dictionary entry: a run of earlier output.
   typedef struct packed {
      logic [11:0] len;
      logic [15:0] start;
   } dict_entry_type;

endpackage

/* hw/rtl/lhd_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lhd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/lzw_history_decoder_core.sv */
// Top level of the LZW history decoder: bit unpacking, dictionary and copy control.
// Depends on lhd_pkg and two lhd_ram instances (dictionary and output history).
`timescale 1ns / 1ps

// Usage:
// The req channel carries one beat per item: a compressed byte (kind 0) or a
// drain request (kind 1). Each accepted beat gives exactly one rsp beat with the
// decoded byte, if any, and the decoder status. Compressed bytes are cut MSB
// first into 9 to 12 bit codes; a code only sets up a copy from the output
// history, and the bytes of that copy leave one per drain beat.
// The csr channel writes the output limit; it is always ready. The limit must be
// written only while the decoder is idle; the block itself does not enforce this.
// A req beat passes the second stage and then the rsp register. One beat per
// cycle is accepted, except after a code that refers to a stored dictionary
// entry: the entry is read from the dictionary RAM and the next beat waits for it.
// A full rsp register with rsp_ready low holds the second stage, and req_ready
// falls as soon as that stage cannot move on.
// Reset empties both stages and restores the decoder state; the dictionary needs
// no clearing pass, because only entries below the fill count are ever read.

module lzw_history_decoder_core (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  lhd_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output lhd_pkg::rsp_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [16:0]     csr_data
);

   // Decoder state.
   logic [23:0] buf_ff, buf_in;
   logic [4:0]  held_ff, held_in;
   logic [3:0]  cw_ff, cw_in;
   logic [12:0] ne_ff, ne_in;
   logic [11:0] plen_ff, plen_in;
   logic        pv_ff, pv_in;
   logic [16:0] wp_ff, wp_in;
   logic [15:0] src_ff, src_in;
   logic [11:0] rem_ff, rem_in;
   logic [2:0]  stop_ff, stop_in;
   logic        fin_ff, fin_in;
   logic [16:0] limit_ff;

   // Second stage.
   logic        s2_valid_ff, s2_valid_in;
   logic        s2_drain_ff, s2_drain_in;
   logic        s2_lit_ff, s2_lit_in;
   logic        s2_lookup_ff, s2_lookup_in;
   logic [15:0] s2_addr_ff, s2_addr_in;
   logic [11:0] s2_code_ff, s2_code_in;
   logic [7:0]  s2_lit_byte_ff, s2_lit_byte_in;
   logic        s2_fwd_ff, s2_fwd_in;
   logic [7:0]  s2_fwd_byte_ff, s2_fwd_byte_in;

   // Response register.
   logic                rsp_valid_ff;
   lhd_pkg::rsp_type    rsp_data_ff;
   lhd_pkg::rsp_type    rsp_next;

   logic        accept;
   logic        adv2;

   // Unpacker signals.
   logic [23:0] buf_x;
   logic [4:0]  held_x;
   logic [4:0]  shift;
   logic [11:0] code;
   logic [11:0] code_mask;
   logic [23:0] keep_mask;
   logic        do_cut;

   // Decode helpers.
   logic [11:0] len_old;
   logic [15:0] back;
   logic [11:0] kw_count;
   logic [11:0] count;
   logic [16:0] room;
   logic [12:0] ne_next;
   logic        is_lit;
   logic        is_valid;

   // Memory ports.
   logic                     dict_we;
   logic                     dict_re;
   logic                     dict_fix;
   logic                     dict_wr_en;
   logic [11:0]              dict_wr_addr;
   lhd_pkg::dict_entry_type  dict_wdata;
   lhd_pkg::dict_entry_type  dict_wr_data;
   lhd_pkg::dict_entry_type  dict_q;
   logic [27:0]              dict_q_bits;
   logic                     hist_re;
   logic                     hist_we;
   logic [7:0]               hist_q;
   logic [7:0]               hist_byte;
   logic [7:0]               hist_wdata;

   // Lookup completion.
   logic [11:0] lk_rem;
   logic [2:0]  lk_stop;

   assign accept    = req_valid & req_ready;
   assign adv2      = s2_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = (~s2_valid_ff | adv2) & ~(s2_valid_ff & s2_lookup_ff);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Bit buffer after this beat's byte, and the code cut from its top.
   assign buf_x     = (req_data.kind == lhd_pkg::KIND_BYTE) ?
                      {buf_ff[15:0], req_data.data_byte} : buf_ff;
   assign held_x    = (req_data.kind == lhd_pkg::KIND_BYTE) ? held_ff + 5'd8 : held_ff;
   assign shift     = held_x - {1'b0, cw_ff};
   assign code_mask = 12'((13'd1 << cw_ff) - 13'd1);
   assign code      = 12'(buf_x >> shift) & code_mask;
   assign keep_mask = (24'd1 << shift) - 24'd1;

   // The new entry is the previous string plus one byte, placed just before
   // the current write position.
   assign len_old  = pv_ff ? plen_ff : 12'd0;
   assign back     = wp_ff[15:0] - {4'd0, len_old};
   assign kw_count = (len_old < lhd_pkg::LEN_MAX) ? len_old + 12'd1 : lhd_pkg::LEN_MAX;
   assign room     = limit_ff - wp_ff;
   assign ne_next  = ne_ff + 13'd1;
   assign is_lit   = (code < lhd_pkg::CODE_CLEAR);
   assign is_valid = ({1'b0, code} >= lhd_pkg::FIRST_ENTRY) && ({1'b0, code} < ne_ff);

   assign dict_wdata.len   = kw_count;
   assign dict_wdata.start = back;
   assign dict_q           = lhd_pkg::dict_entry_type'(dict_q_bits);

   // A stored entry that was just used now starts at the copy's write position.
   // No beat is taken in that cycle, so the write port is free.
   assign dict_fix     = adv2 & s2_lookup_ff;
   assign dict_wr_en   = dict_we | dict_fix;
   assign dict_wr_addr = dict_fix ? s2_code_ff : ne_ff[lhd_pkg::DICT_BITS-1:0];

   always_comb begin
      dict_wr_data = dict_wdata;
      if (dict_fix) begin
         dict_wr_data.len   = dict_q.len;
         dict_wr_data.start = s2_addr_ff;
      end
   end

   // History byte of a drain beat, forwarded when the write landed in the read cycle.
   assign hist_byte  = s2_fwd_ff ? s2_fwd_byte_ff : hist_q;
   assign hist_wdata = s2_lit_ff ? s2_lit_byte_ff : hist_byte;
   assign hist_we    = adv2 & (s2_drain_ff | s2_lit_ff);

   // Copy setup for a stored entry, once its read data is back.
   always_comb begin
      lk_rem  = dict_q.len;
      lk_stop = stop_ff;
      if ({5'd0, dict_q.len} >= room) begin
         lk_rem  = room[11:0];
         lk_stop = lhd_pkg::RUN_LIMIT;
      end
   end

   // First stage: unpack, decode and step the copy.
   always_comb begin
      buf_in  = buf_ff;
      held_in = held_ff;
      cw_in   = cw_ff;
      ne_in   = ne_ff;
      plen_in = plen_ff;
      pv_in   = pv_ff;
      wp_in   = wp_ff;
      src_in  = src_ff;
      rem_in  = rem_ff;
      stop_in = stop_ff;
      fin_in  = fin_ff;
      s2_drain_in    = 1'b0;
      s2_lit_in      = 1'b0;
      s2_lookup_in   = 1'b0;
      s2_addr_in     = wp_ff[15:0];
      s2_code_in     = code;
      s2_lit_byte_in = code[7:0];
      s2_fwd_in      = 1'b0;
      s2_fwd_byte_in = hist_wdata;
      dict_we = 1'b0;
      dict_re = 1'b0;
      hist_re = 1'b0;
      do_cut  = 1'b0;
      count   = 12'd1;

      if (accept) begin
         if (req_data.kind == lhd_pkg::KIND_BYTE) begin
            if (stop_ff == lhd_pkg::RUN_GO && !fin_ff && held_ff <= 5'd16) begin
               buf_in  = buf_x;
               held_in = held_x;
               fin_in  = fin_ff | req_data.final_byte;
               if (rem_ff == 12'd0 && held_x >= {1'b0, cw_ff}) begin
                  do_cut = 1'b1;
               end
            end
         end else if (rem_ff != 12'd0) begin
            hist_re     = 1'b1;
            src_in      = src_ff + 16'd1;
            rem_in      = rem_ff - 12'd1;
            wp_in       = wp_ff + 17'd1;
            s2_drain_in = 1'b1;
            s2_fwd_in   = s2_valid_ff & (s2_drain_ff | s2_lit_ff) & (s2_addr_ff == src_ff);
         end else if (stop_ff == lhd_pkg::RUN_GO && held_ff >= {1'b0, cw_ff}) begin
            do_cut = 1'b1;
         end
      end

      if (do_cut) begin
         held_in = shift;
         buf_in  = buf_x & keep_mask;
         if (wp_ff >= limit_ff) begin
            stop_in = lhd_pkg::RUN_LIMIT;
         end else if (code == lhd_pkg::CODE_CLEAR) begin
            cw_in = lhd_pkg::MIN_CODE_BITS;
            ne_in = lhd_pkg::FIRST_ENTRY;
            pv_in = 1'b0;
         end else if (code == lhd_pkg::CODE_END) begin
            stop_in = lhd_pkg::RUN_END;
         end else if ({1'b0, code} >= lhd_pkg::FIRST_ENTRY && !pv_ff) begin
            stop_in = lhd_pkg::RUN_BAD;
         end else begin
            pv_in = 1'b1;
            if (is_lit) begin
               src_in    = wp_ff[15:0];
               count     = 12'd1;
               plen_in   = 12'd1;
               s2_lit_in = 1'b1;
            end else if (is_valid) begin
               dict_re      = 1'b1;
               s2_lookup_in = 1'b1;
            end else begin
               // Code with no entry yet: previous string plus its own first byte.
               src_in  = back;
               count   = kw_count;
               plen_in = ({1'b0, code} == ne_ff && !ne_ff[12]) ? kw_count : 12'd0;
            end
            if (pv_ff && !ne_ff[12]) begin
               dict_we = 1'b1;
               ne_in   = ne_next;
               if (((14'(ne_next) + 14'd1) >> cw_ff) != 14'd0 &&
                   cw_ff < 4'(lhd_pkg::MAX_CODE_BITS)) begin
                  cw_in = cw_ff + 4'd1;
               end
            end
            if (!is_valid) begin
               if ({5'd0, count} >= room) begin
                  rem_in  = room[11:0];
                  stop_in = lhd_pkg::RUN_LIMIT;
               end else begin
                  rem_in = count;
               end
            end
         end
      end

      // Input ran out: too few bits left for a whole code.
      if (accept && !s2_lookup_in && stop_in == lhd_pkg::RUN_GO && fin_in &&
          rem_in == 12'd0 && held_in < {1'b0, cw_in}) begin
         stop_in = lhd_pkg::RUN_EOF;
      end

      // Second stage finishes a stored-entry decode; no beat is taken meanwhile.
      if (adv2 && s2_lookup_ff) begin
         src_in  = dict_q.start;
         plen_in = dict_q.len;
         rem_in  = lk_rem;
         stop_in = lk_stop;
      end
   end

   // Response of the beat in the second stage.
   always_comb begin
      rsp_next.out_byte       = s2_drain_ff ? hist_byte : 8'd0;
      rsp_next.out_valid      = s2_drain_ff;
      rsp_next.more_pending   = s2_lookup_ff ? (lk_rem != 12'd0) : (rem_ff != 12'd0);
      rsp_next.run_state      = s2_lookup_ff ? lk_stop : stop_ff;
      rsp_next.bytes_produced = wp_ff;
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (accept) begin
         s2_valid_in = 1'b1;
      end else if (adv2) begin
         s2_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff       <= '0;
         held_ff      <= '0;
         cw_ff        <= lhd_pkg::MIN_CODE_BITS;
         ne_ff        <= lhd_pkg::FIRST_ENTRY;
         plen_ff      <= '0;
         pv_ff        <= 1'b0;
         wp_ff        <= '0;
         src_ff       <= '0;
         rem_ff       <= '0;
         stop_ff      <= lhd_pkg::RUN_GO;
         fin_ff       <= 1'b0;
         limit_ff     <= lhd_pkg::LIMIT_RESET;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         buf_ff      <= buf_in;
         held_ff     <= held_in;
         cw_ff       <= cw_in;
         ne_ff       <= ne_in;
         plen_ff     <= plen_in;
         pv_ff       <= pv_in;
         wp_ff       <= wp_in;
         src_ff      <= src_in;
         rem_ff      <= rem_in;
         stop_ff     <= stop_in;
         fin_ff      <= fin_in;
         s2_valid_ff <= s2_valid_in;
         if (csr_valid) begin
            limit_ff <= csr_data;
         end
         if (adv2) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s2_drain_ff    <= s2_drain_in;
         s2_lit_ff      <= s2_lit_in;
         s2_lookup_ff   <= s2_lookup_in;
         s2_addr_ff     <= s2_addr_in;
         s2_code_ff     <= s2_code_in;
         s2_lit_byte_ff <= s2_lit_byte_in;
         s2_fwd_ff      <= s2_fwd_in;
         s2_fwd_byte_ff <= s2_fwd_byte_in;
      end
      if (adv2) begin
         rsp_data_ff <= rsp_next;
      end
   end

   // Dictionary: length and start of each stored entry.
   lhd_ram #(
      .WIDTH($bits(lhd_pkg::dict_entry_type)),
      .DEPTH(lhd_pkg::DICT_ENTRIES)
   ) u_dict (
      .clock  (clock),
      .wr_en  (dict_wr_en),
      .wr_addr(dict_wr_addr),
      .wr_data(dict_wr_data),
      .rd_en  (dict_re),
      .rd_addr(code[lhd_pkg::DICT_BITS-1:0]),
      .rd_data(dict_q_bits)
   );

   // Output history window.
   lhd_ram #(
      .WIDTH(8),
      .DEPTH(lhd_pkg::HISTORY_BYTES)
   ) u_hist (
      .clock  (clock),
      .wr_en  (hist_we),
      .wr_addr(s2_addr_ff[lhd_pkg::HIST_BITS-1:0]),
      .wr_data(hist_wdata),
      .rd_en  (hist_re),
      .rd_addr(src_ff[lhd_pkg::HIST_BITS-1:0]),
      .rd_data(hist_q)
   );

endmodule

/* verif/lhd_decode_checker.sv */
// Checker of the LZW history decoder: watches the req, rsp and csr channels,
// predicts every rsp beat and compares it field by field. Depends on lhd_pkg.
`timescale 1ns / 1ps

module lhd_decode_checker
   import lhd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [16:0] csr_data,
   output int          error_count,
   output int          beats_owed,
   output logic [16:0] bytes_written
);

   // Predicted decoder state.
   logic [7:0]  history [HISTORY_BYTES];
   logic [11:0] entry_len [DICT_ENTRIES];
   logic [15:0] entry_pos [DICT_ENTRIES];
   logic [23:0] bit_buf;
   logic [4:0]  bits_held;
   logic [3:0]  code_width;
   logic [12:0] next_entry;
   logic [11:0] prev_code;
   logic        prev_valid;
   logic [16:0] write_pos;
   logic [15:0] copy_src;
   logic [11:0] copy_left;
   logic [2:0]  stop_code;
   logic        final_seen;
   logic [16:0] output_limit;

   rsp_type owed_beats [$];
   int      errors = 0;

   assign error_count = errors;

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("rsp mismatch on %s: got %0d, expected %0d", field, got, want);
      errors++;
   endtask

   // Apply one code: set up the copy and grow the dictionary.
   task automatic decode_code(input logic [11:0] code);
      logic [11:0] len_old;
      logic [11:0] count;
      logic [11:0] grown;
      logic [15:0] wpm;
      logic [15:0] back;
      logic [15:0] src;
      logic [16:0] room;
      if (write_pos >= output_limit) begin
         stop_code = RUN_LIMIT;
         return;
      end
      if (code == CODE_CLEAR) begin
         for (int i = FIRST_ENTRY; i < DICT_ENTRIES; i++) entry_len[i] = '0;
         code_width = MIN_CODE_BITS;
         next_entry = FIRST_ENTRY;
         prev_valid = 1'b0;
         return;
      end
      if (code == CODE_END) begin
         stop_code = RUN_END;
         return;
      end
      if (code >= FIRST_ENTRY && !prev_valid) begin
         stop_code = RUN_BAD;
         return;
      end
      len_old = prev_valid ? entry_len[prev_code] : 12'd0;
      grown = (len_old < LEN_MAX) ? len_old + 12'd1 : LEN_MAX;
      wpm = write_pos[15:0];
      back = wpm - {4'd0, len_old};
      if (code < 12'd256) begin
         history[wpm] = code[7:0];
         src = wpm;
         count = 12'd1;
      end else if (entry_len[code] != '0) begin
         src = entry_pos[code];
         count = entry_len[code];
         entry_pos[code] = wpm;
      end else begin
         // Code with no entry yet: previous string plus its own first byte.
         src = back;
         count = grown;
      end
      if (prev_valid && next_entry < DICT_ENTRIES) begin
         entry_len[next_entry[11:0]] = grown;
         entry_pos[next_entry[11:0]] = back;
         next_entry = next_entry + 13'd1;
         if (((next_entry + 13'd1) >> code_width) != 0 && code_width < MAX_CODE_BITS)
            code_width = code_width + 4'd1;
      end
      prev_code = code;
      prev_valid = 1'b1;
      room = output_limit - write_pos;
      if ({5'd0, count} >= room) begin
         count = room[11:0];
         stop_code = RUN_LIMIT;
      end
      copy_src = src;
      copy_left = count;
   endtask

   task automatic cut_code();
      logic [4:0]  shift;
      logic [11:0] code;
      shift = bits_held - {1'b0, code_width};
      code = 12'((bit_buf >> shift) & ((24'd1 << code_width) - 24'd1));
      bits_held = shift;
      bit_buf = bit_buf & ((24'd1 << bits_held) - 24'd1);
      decode_code(code);
   endtask

   // One req beat in, one predicted rsp beat out.
   task automatic decode_beat(input req_type req, output rsp_type rsp);
      logic [7:0] ob;
      logic       ov;
      ob = '0;
      ov = 1'b0;
      if (req.kind == KIND_BYTE) begin
         if (stop_code == RUN_GO && !final_seen && bits_held <= 5'd16) begin
            bit_buf = {bit_buf[15:0], req.data_byte};
            bits_held = bits_held + 5'd8;
            if (req.final_byte) final_seen = 1'b1;
            if (copy_left == '0 && bits_held >= code_width) cut_code();
         end
      end else if (copy_left != '0) begin
         ob = history[copy_src];
         history[write_pos[15:0]] = ob;
         copy_src = copy_src + 16'd1;
         copy_left = copy_left - 12'd1;
         write_pos = write_pos + 17'd1;
         ov = 1'b1;
      end else if (stop_code == RUN_GO && bits_held >= code_width) begin
         cut_code();
      end
      if (stop_code == RUN_GO && final_seen && copy_left == '0 && bits_held < code_width)
         stop_code = RUN_EOF;
      rsp.out_byte = ob;
      rsp.out_valid = ov;
      rsp.more_pending = (copy_left != '0);
      rsp.run_state = stop_code;
      rsp.bytes_produced = write_pos;
   endtask

   // Track every handshake at the clock edge.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type made;
      if (reset) begin
         for (int i = 0; i < DICT_ENTRIES; i++) begin
            entry_len[i] = (i < 256) ? 12'd1 : 12'd0;
            entry_pos[i] = '0;
         end
         bit_buf = '0;
         bits_held = '0;
         code_width = MIN_CODE_BITS;
         next_entry = FIRST_ENTRY;
         prev_code = '0;
         prev_valid = 1'b0;
         write_pos = '0;
         copy_src = '0;
         copy_left = '0;
         stop_code = RUN_GO;
         final_seen = 1'b0;
         output_limit = LIMIT_RESET;
         owed_beats.delete();
      end else begin
         if (csr_valid && csr_ready) output_limit = csr_data;
         if (rsp_valid && rsp_ready) begin
            if (owed_beats.size() == 0) begin
               report_mismatch("unexpected beat", rsp_data.bytes_produced, -1);
            end else begin
               want = owed_beats.pop_front();
               if (rsp_data.out_byte !== want.out_byte)
                  report_mismatch("out_byte", rsp_data.out_byte, want.out_byte);
               if (rsp_data.out_valid !== want.out_valid)
                  report_mismatch("out_valid", rsp_data.out_valid, want.out_valid);
               if (rsp_data.more_pending !== want.more_pending)
                  report_mismatch("more_pending", rsp_data.more_pending, want.more_pending);
               if (rsp_data.run_state !== want.run_state)
                  report_mismatch("run_state", rsp_data.run_state, want.run_state);
               if (rsp_data.bytes_produced !== want.bytes_produced)
                  report_mismatch("bytes_produced", rsp_data.bytes_produced,
                                  want.bytes_produced);
            end
         end
         if (req_valid && req_ready) begin
            decode_beat(req_data, made);
            owed_beats.push_back(made);
         end
      end
      beats_owed <= owed_beats.size();
      bytes_written <= write_pos;
   end

endmodule

/* verif/testbench.sv */
// Top of the LZW history decoder testbench: builds well-formed code streams,
// drives req and csr beats, stalls rsp, and gives the verdict.
// Depends on lhd_pkg, lzw_history_decoder_core and lhd_decode_checker.
`timescale 1ns / 1ps

module testbench;
   import lhd_pkg::*;

   localparam int STALL_LIMIT  = 3000;
   localparam int RANDOM_ITEMS = 1750;

   // Ways the stream can end.
   localparam int FINISH_END_CODE = 0;
   localparam int FINISH_LIMIT    = 1;
   localparam int FINISH_EOF      = 2;
   localparam int FINISH_BAD      = 3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [16:0] csr_data = '0;

   int          error_count;
   int          beats_owed;
   logic [16:0] bytes_written;
   int          idle_cycles = 0;
   int          item_count = 0;
   bit          burst = 1'b0;

   // Encoder view of the stream: widths and string lengths of every code.
   int unsigned enc_width;
   int unsigned enc_next;
   bit          enc_prev_valid;
   int unsigned enc_prev_len;
   int unsigned enc_len [DICT_ENTRIES];
   logic [31:0] pack_bits;
   int unsigned pack_count;
   int unsigned held_bits = 0;
   int unsigned uncut_width [$];
   int unsigned uncut_len [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lzw_history_decoder_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   lhd_decode_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .beats_owed    (beats_owed),
      .bytes_written (bytes_written)
   );

   // Watchdog: too long without any beat on any channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Receiver: random stall before each rsp beat, with bursts of none.
   initial begin
      int stall;
      forever begin
         stall = burst ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // One req beat; called and returns at a falling edge.
   task automatic send_req(input logic kind, input logic [7:0] data, input logic fin);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{kind: kind, data_byte: data, final_byte: fin};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      item_count++;
      if (item_count % 64 == 0) burst = ($urandom_range(0, 3) == 0);
   endtask

   task automatic send_drain();
      send_req(KIND_DRAIN, 8'($urandom), 1'($urandom));
   endtask

   // A compressed byte; once it completes a code, drain that code's bytes, now and then with one drain more.
   task automatic send_byte(input logic [7:0] data, input logic fin);
      int unsigned len;
      send_req(KIND_BYTE, data, fin);
      held_bits += 8;
      if (uncut_width.size() > 0 && held_bits >= uncut_width[0]) begin
         held_bits -= uncut_width.pop_front();
         len = uncut_len.pop_front();
         repeat (len) send_drain();
         if ($urandom_range(0, 7) == 0) send_drain();
      end
   endtask

   task automatic enc_clear();
      for (int i = 0; i < DICT_ENTRIES; i++) enc_len[i] = (i < 256) ? 1 : 0;
      enc_width = MIN_CODE_BITS;
      enc_next = FIRST_ENTRY;
      enc_prev_valid = 1'b0;
      enc_prev_len = 0;
   endtask

   // Pack one code MSB first; with fin the last byte carries the final mark.
   task automatic put_code(input int unsigned code, input bit fin);
      int unsigned w;
      int unsigned len;
      w = enc_width;
      if (code == CODE_CLEAR) begin
         enc_clear();
         len = 0;
      end else if (code == CODE_END) begin
         len = 0;
      end else begin
         if (code < 256) len = 1;
         else if (enc_len[code] > 0) len = enc_len[code];
         else len = enc_prev_len + 1;
         if (enc_prev_valid && enc_next < DICT_ENTRIES) begin
            enc_len[enc_next] = enc_prev_len + 1;
            enc_next++;
            if (((enc_next + 1) >> enc_width) != 0 && enc_width < MAX_CODE_BITS)
               enc_width++;
         end
         // The decoder takes the previous length from the entry, which is
         // empty for a code beyond the next free one.
         enc_prev_len = (code < 256) ? 1 : enc_len[code];
         enc_prev_valid = 1'b1;
      end
      uncut_width.push_back(w);
      uncut_len.push_back(len);
      pack_bits = (pack_bits << w) | code;
      pack_count += w;
      while (pack_count >= 8) begin
         send_byte(8'(pack_bits >> (pack_count - 8)), fin && pack_count == 8);
         pack_count -= 8;
         pack_bits &= (32'd1 << pack_count) - 1;
      end
      if (fin && pack_count > 0) begin
         send_byte(8'(pack_bits << (8 - pack_count)), 1'b1);
         pack_count = 0;
         pack_bits = '0;
      end
   endtask

   // A well-formed code: literal, stored entry, unknown code or clear.
   // Unknown codes need a nonempty previous string to copy from.
   function automatic int unsigned pick_code();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!enc_prev_valid) return $urandom_range(0, 255);
      if (r < 3) return CODE_CLEAR;
      if (r < 45) return $urandom_range(0, 255);
      if (r < 60 && enc_next < DICT_ENTRIES && enc_prev_len > 0) return enc_next;
      if (r < 65 && enc_next < DICT_ENTRIES && enc_prev_len > 0)
         return $urandom_range(enc_next, (1 << enc_width) - 1);
      if (enc_next > FIRST_ENTRY) return $urandom_range(FIRST_ENTRY, enc_next - 1);
      return $urandom_range(0, 255);
   endfunction

   task automatic wait_idle();
      while (beats_owed != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(input logic [16:0] value);
      req_valid <= 1'b0;
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      enc_clear();
      pack_bits = '0;
      pack_count = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_limit(LIMIT_RESET);

      // Directed: literal extremes, unknown codes, stored entries, a clear.
      put_code(0, 0);
      put_code(255, 0);
      put_code(259, 0);
      put_code(258, 0);
      put_code(300, 0);
      put_code(259, 0);
      put_code(128, 0);
      put_code(CODE_CLEAR, 0);
      put_code(65, 0);
      put_code(258, 0);
      put_code(66, 0);
      put_code(259, 0);

      // Random well-formed stream with clears along the way.
      while (item_count < RANDOM_ITEMS) put_code(pick_code(), 0);

      // One way of stopping per run.
      case ($urandom_range(FINISH_END_CODE, FINISH_BAD))
         FINISH_END_CODE: put_code(CODE_END, 1);
         FINISH_LIMIT: begin
            write_limit(bytes_written + 17'($urandom_range(1, 40)));
            repeat (60) put_code(pick_code(), 0);
            put_code($urandom_range(0, 255), 1);
         end
         FINISH_EOF: begin
            if ($urandom_range(0, 1)) begin
               // Make the last code end exactly on the last input bit.
               put_code(CODE_CLEAR, 0);
               while ((pack_count + enc_width) % 8 != 0) put_code($urandom_range(0, 255), 0);
            end
            put_code($urandom_range(0, 255), 1);
         end
         default: begin
            put_code(CODE_CLEAR, 0);
            put_code($urandom_range(FIRST_ENTRY, 511), 1);
         end
      endcase

      // After the stop: bytes are ignored, drains still answer.
      repeat (6) begin
         send_req(KIND_BYTE, 8'($urandom), 1'($urandom));
         send_drain();
      end
      write_limit(17'd1);
      repeat (4) send_drain();
      req_valid <= 1'b0;

      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/lhd_pkg.sv
hw/rtl/lhd_ram.sv
hw/rtl/lzw_history_decoder_core.sv
verif/lhd_decode_checker.sv
verif/testbench.sv
